// ----- rtl/ssm_pkg.sv -----
// ----------------------------------------------------------------------------
// ssm_pkg: shared types and constants of the skid-steer throttle mixer
// Holds the widths of the shared divide and root units, their status struct,
// the sequencer state type and the register and output-mode codes.
// ----------------------------------------------------------------------------
package ssm_pkg;

  // shared divider: numerator width, divisor width, step counter width
  localparam int unsigned DIV_NW = 44;
  localparam int unsigned DIV_DW = 30;
  localparam int unsigned DIV_CW = $clog2(DIV_NW + 1);

  // shared square root: radicand width (even), root width, counter width
  localparam int unsigned SQ_W  = 54;
  localparam int unsigned SQ_RW = SQ_W / 2;
  localparam int unsigned SQ_CW = $clog2(SQ_RW + 1);

  // configuration register indexes
  localparam logic [2:0] CFG_CEILING = 3'd0;
  localparam logic [2:0] CFG_FLOOR   = 3'd1;
  localparam logic [2:0] CFG_SLEW    = 3'd2;
  localparam logic [2:0] CFG_EXPO    = 3'd3;
  localparam logic [2:0] CFG_DZPWM   = 3'd4;
  localparam logic [2:0] CFG_RELAY   = 3'd5;
  localparam logic [2:0] CFG_REVERSE = 3'd6;

  // output modes
  localparam logic [1:0] MODE_DRIVE = 2'd0;
  localparam logic [1:0] MODE_TRIM  = 2'd1;
  localparam logic [1:0] MODE_ZERO  = 2'd2;

  typedef struct packed {
    logic busy;
    logic done;
  } ssm_unit_st_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SLEW,
    ST_CALC,
    ST_MIXL,
    ST_MIXR,
    ST_FLR,
    ST_EXP1,
    ST_EXP2,
    ST_SQRT,
    ST_EXPD,
    ST_REL,
    ST_DONE
  } ssm_state_e;

endpackage

// ----- rtl/ssm_div.sv -----
// ----------------------------------------------------------------------------
// ssm_div: iterative unsigned divider
// Restoring division, one quotient bit per cycle; done pulses for one cycle.
// ----------------------------------------------------------------------------
module ssm_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [ssm_pkg::DIV_NW-1:0]  num_i,
  input  logic [ssm_pkg::DIV_DW-1:0]  den_i,
  output logic [ssm_pkg::DIV_NW-1:0]  quo_o,
  output ssm_pkg::ssm_unit_st_t       st_o
);
  import ssm_pkg::*;

  logic              busy_q, busy_d, done_q, done_d;
  logic [DIV_CW-1:0] cnt_q, cnt_d;
  logic [DIV_DW-1:0] rem_q, rem_d, den_q, den_d;
  logic [DIV_NW-1:0] quo_q, quo_d;
  logic [DIV_DW:0]   rem_sh, diff;
  logic              ge;

  assign rem_sh = {rem_q, quo_q[DIV_NW-1]};
  assign ge     = rem_sh >= {1'b0, den_q};
  assign diff   = rem_sh - {1'b0, den_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    den_d  = den_q;
    quo_d  = quo_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = DIV_CW'(DIV_NW);
      rem_d  = '0;
      den_d  = den_i;
      quo_d  = num_i;
    end else if (busy_q) begin
      // shift in the next numerator bit, subtract when it fits
      rem_d = ge ? diff[DIV_DW-1:0] : rem_sh[DIV_DW-1:0];
      quo_d = {quo_q[DIV_NW-2:0], ge};
      cnt_d = cnt_q - DIV_CW'(1);
      if (cnt_q == DIV_CW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    den_q <= den_d;
    quo_q <= quo_d;
  end

  assign quo_o     = quo_q;
  assign st_o.busy = busy_q;
  assign st_o.done = done_q;

endmodule

// ----- rtl/ssm_sqrt.sv -----
// ----------------------------------------------------------------------------
// ssm_sqrt: iterative integer square root
// Digit recurrence, two radicand bits per cycle; gives the floor of the root.
// ----------------------------------------------------------------------------
module ssm_sqrt (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [ssm_pkg::SQ_W-1:0]    rad_i,
  output logic [ssm_pkg::SQ_RW-1:0]   root_o,
  output ssm_pkg::ssm_unit_st_t       st_o
);
  import ssm_pkg::*;

  logic             busy_q, busy_d, done_q, done_d;
  logic [SQ_CW-1:0] cnt_q, cnt_d;
  logic [SQ_W-1:0]  rad_q, rad_d;
  logic [SQ_RW:0]   rem_q, rem_d;
  logic [SQ_RW-1:0] root_q, root_d;
  logic [SQ_RW+2:0] rem_sh, trial, rem_sub;
  logic             ge;

  assign rem_sh  = {rem_q, rad_q[SQ_W-1:SQ_W-2]};
  assign trial   = {1'b0, root_q, 2'b01};
  assign ge      = rem_sh >= trial;
  assign rem_sub = rem_sh - trial;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rad_d  = rad_q;
    rem_d  = rem_q;
    root_d = root_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = SQ_CW'(SQ_RW);
      rad_d  = rad_i;
      rem_d  = '0;
      root_d = '0;
    end else if (busy_q) begin
      rad_d  = {rad_q[SQ_W-3:0], 2'b00};
      rem_d  = ge ? rem_sub[SQ_RW:0] : rem_sh[SQ_RW:0];
      root_d = {root_q[SQ_RW-2:0], ge};
      cnt_d  = cnt_q - SQ_CW'(1);
      if (cnt_q == SQ_CW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rad_q  <= rad_d;
    rem_q  <= rem_d;
    root_q <= root_d;
  end

  assign root_o    = root_q;
  assign st_o.busy = busy_q;
  assign st_o.done = done_q;

endmodule

// ----- rtl/skid_steer_throttle_mixer.sv -----
// ----------------------------------------------------------------------------
// skid_steer_throttle_mixer: throttle and steering mixer for skid steering
// Slew-limited throttle, normalized mix to left and right drive, minimum
// throttle offset, square-root thrust curve and direction relays.
// ----------------------------------------------------------------------------
// One input transaction per control tick gives one result transaction. The
// block works on one tick at a time under a small sequencer that reuses one
// 44-step divider and one 27-step square root unit, so in_ready_o is low
// while a tick is in work. The slew step runs only when slew limiting is
// on, and the curve steps only when the thrust curve is on. A drive value
// of zero skips its floor and curve steps. A disarmed tick skips the mix.
// The result sits in an output register, so the next tick is taken while
// it waits.
// Configuration writes are always accepted (cfg_ready_o is tied high).
module skid_steer_throttle_mixer (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [2:0]         cfg_addr_i,
  input  logic [10:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               armed_i,
  input  logic signed [14:0] throttle_request_i,
  input  logic signed [15:0] steering_request_i,
  input  logic [15:0]        dt_us_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [14:0] left_drive_o,
  output logic signed [14:0] right_drive_o,
  output logic               relay_left_o,
  output logic               relay_right_o,
  output logic [1:0]         output_mode_o,
  output logic               steer_left_limit_o,
  output logic               steer_right_limit_o,
  output logic               throttle_lower_limit_o,
  output logic               throttle_upper_limit_o
);
  import ssm_pkg::*;

  // configuration registers
  logic [6:0]         ceil_reg_q;
  logic [4:0]         floor_reg_q;
  logic [9:0]         slew_q;
  logic signed [10:0] expo_q;
  logic               dzpwm_q, relay_q;
  logic [1:0]         rmask_q;

  // sequencer and working registers
  ssm_state_e         state_q, state_d;
  logic               issued_q, issued_d;
  logic               k_q, k_d;
  logic               armed_q, armed_d;
  logic signed [14:0] treq_q, treq_d;
  logic signed [15:0] sreq_q, sreq_d;
  logic [15:0]        dt_q, dt_d;
  logic signed [14:0] last_q, last_d;
  logic [12:0]        step_q, step_d;
  logic signed [14:0] thr_q, thr_d;
  logic [3:0]         lim_q, lim_d;   // steer left, steer right, thr lower, thr upper
  logic signed [14:0] drv_q [2];
  logic signed [14:0] drv_d [2];
  logic [1:0]         rel_q, rel_d;
  logic signed [14:0] xs_q, xs_d;
  logic               neg_q, neg_d;
  logic [13:0]        mag_q, mag_d;
  logic [10:0]        u_q, u_d;
  logic [21:0]        sq_q, sq_d;
  logic signed [25:0] em_q, em_d;
  logic [28:0]        n_q, n_d;

  // output register
  logic               ov_q, ov_d;
  logic signed [14:0] ol_q, ol_d, or_q, or_d;
  logic               orl_q, orl_d, orr_q, orr_d;
  logic [1:0]         om_q, om_d;
  logic [3:0]         olim_q, olim_d;

  // shared units
  logic               div_start, sq_start;
  logic [DIV_NW-1:0]  div_num, div_quo;
  logic [DIV_DW-1:0]  div_den;
  logic [SQ_RW-1:0]   sq_root;
  ssm_unit_st_t       div_st, sq_st;

  ssm_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .quo_o   (div_quo),
    .st_o    (div_st)
  );

  ssm_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sq_start),
    .rad_i   ({1'b0, n_q, 24'd0}),
    .root_o  (sq_root),
    .st_o    (sq_st)
  );

  // configuration writes; unlisted indexes drop
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ceil_reg_q  <= 7'd100;
      floor_reg_q <= 5'd0;
      slew_q      <= 10'd100;
      expo_q      <= 11'sd0;
      dzpwm_q     <= 1'b0;
      relay_q     <= 1'b0;
      rmask_q     <= 2'd0;
    end else if (cfg_valid_i) begin
      case (cfg_addr_i)
        CFG_CEILING: ceil_reg_q  <= cfg_data_i[6:0];
        CFG_FLOOR:   floor_reg_q <= cfg_data_i[4:0];
        CFG_SLEW:    slew_q      <= cfg_data_i[9:0];
        CFG_EXPO:    expo_q      <= $signed(cfg_data_i);
        CFG_DZPWM:   dzpwm_q     <= cfg_data_i[0];
        CFG_RELAY:   relay_q     <= cfg_data_i[0];
        CFG_REVERSE: rmask_q     <= cfg_data_i[1:0];
        default: ;
      endcase
    end
  end

  // constrained limits
  logic [6:0]         ceil_pct;
  logic [13:0]        ceil_v;
  logic [4:0]         fl;
  logic               expo_on;

  assign ceil_pct = (ceil_reg_q < 7'd30) ? 7'd30 :
                    (ceil_reg_q > 7'd100) ? 7'd100 : ceil_reg_q;
  assign ceil_v   = 14'(ceil_pct) * 14'd100;
  assign fl       = (floor_reg_q > 5'd20) ? 5'd20 : floor_reg_q;
  assign expo_on  = (expo_q != 11'sd0) && (expo_q >= -11'sd1000) && (expo_q <= 11'sd1000);

  // throttle clamp and slew window
  logic signed [16:0] treq_s, ceil_s, thr_c, last_s, step_s, win_lo, win_hi, thr_sl;

  assign treq_s = 17'(treq_q);
  assign ceil_s = $signed({3'b000, ceil_v});
  assign thr_c  = !armed_q ? 17'sd0 :
                  (treq_s > ceil_s) ? ceil_s :
                  (treq_s < -ceil_s) ? -ceil_s : treq_s;
  assign last_s = 17'(last_q);
  assign step_s = $signed({4'b0000, step_q});
  assign win_lo = last_s - step_s;
  assign win_hi = last_s + step_s;
  assign thr_sl = (slew_q == 10'd0) ? thr_c :
                  (thr_c < win_lo) ? win_lo :
                  (thr_c > win_hi) ? win_hi : thr_c;

  // mixer operands: left uses thr + steer, right thr - steer
  logic signed [15:0] sc;
  logic signed [19:0] mix_a, mix_b, mix_abs_a, mix_abs_b, mix_sum, mix_mag;
  logic [19:0]        mix_d;
  logic [17:0]        mix_den;

  assign sc        = (sreq_q > 16'sd4500) ? 16'sd4500 :
                     (sreq_q < -16'sd4500) ? -16'sd4500 : sreq_q;
  assign mix_a     = 20'(sc) * 20'sd20;
  assign mix_b     = 20'(thr_q) * 20'sd9;
  assign mix_abs_a = (mix_a < 20'sd0) ? -mix_a : mix_a;
  assign mix_abs_b = (mix_b < 20'sd0) ? -mix_b : mix_b;
  assign mix_d     = $unsigned(mix_abs_a + mix_abs_b);
  assign mix_den   = (mix_d > 20'd90000) ? mix_d[17:0] : 18'd90000;
  assign mix_sum   = (state_q == ST_MIXL) ? (mix_b + mix_a) : (mix_b - mix_a);
  assign mix_mag   = (mix_sum < 20'sd0) ? -mix_sum : mix_sum;

  // floor offset operands
  logic signed [14:0] xk, axk_s, xs_abs;
  logic [14:0]        fl_mag;

  assign xk     = drv_q[k_q];
  assign axk_s  = (xk < 15'sd0) ? -xk : xk;
  assign fl_mag = 15'(fl) * 15'd100 + 15'(div_quo[13:0]);
  assign xs_abs = (xs_q < 15'sd0) ? -xs_q : xs_q;

  // thrust curve operands
  logic [13:0]        mag_v, y_v;
  logic signed [11:0] u_s;
  logic signed [30:0] n_s;
  logic [27:0]        den_e;

  assign mag_v = (xs_abs > 15'sd10000) ? 14'd10000 : xs_abs[13:0];
  assign u_s   = 12'sd1000 - 12'(expo_q);
  assign n_s   = $signed(31'(sq_q)) * 31'sd100 + 31'(em_q) * 31'sd40;
  assign den_e = 28'(sq_root) + ((28'(u_q) * 28'd10) << 12);
  assign y_v   = (div_quo > DIV_NW'(10000)) ? 14'd10000 : div_quo[13:0];

  // relay split
  logic               rev_k, rel_k;
  logic signed [14:0] rel_x;

  assign rev_k = rmask_q[k_q];
  assign rel_k = relay_q && (xs_q != 15'sd0) && ((xs_q < 15'sd0) != rev_k);
  assign rel_x = !relay_q ? xs_q : (rev_k ? -xs_abs : xs_abs);

  // sequencer
  always_comb begin
    state_d   = state_q;
    issued_d  = issued_q;
    k_d       = k_q;
    armed_d   = armed_q;
    treq_d    = treq_q;
    sreq_d    = sreq_q;
    dt_d      = dt_q;
    last_d    = last_q;
    step_d    = step_q;
    thr_d     = thr_q;
    lim_d     = lim_q;
    drv_d[0]  = drv_q[0];
    drv_d[1]  = drv_q[1];
    rel_d     = rel_q;
    xs_d      = xs_q;
    neg_d     = neg_q;
    mag_d     = mag_q;
    u_d       = u_q;
    sq_d      = sq_q;
    em_d      = em_q;
    n_d       = n_q;
    ov_d      = ov_q && !out_ready_i;
    ol_d      = ol_q;
    or_d      = or_q;
    orl_d     = orl_q;
    orr_d     = orr_q;
    om_d      = om_q;
    olim_d    = olim_q;
    div_start = 1'b0;
    div_num   = '0;
    div_den   = DIV_DW'(1);
    sq_start  = 1'b0;
    in_ready_o = 1'b0;

    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          armed_d  = armed_i;
          treq_d   = throttle_request_i;
          sreq_d   = steering_request_i;
          dt_d     = dt_us_i;
          issued_d = 1'b0;
          state_d  = (slew_q != 10'd0) ? ST_SLEW : ST_CALC;
        end
      end
      ST_SLEW: begin
        // step = max(1 %, slew * dt / 10000)
        div_num = DIV_NW'(slew_q) * DIV_NW'(dt_q);
        div_den = DIV_DW'(10000);
        if (!issued_q) begin
          div_start = 1'b1;
          issued_d  = 1'b1;
        end else if (div_st.done) begin
          issued_d = 1'b0;
          step_d   = (div_quo < DIV_NW'(100)) ? 13'd100 : div_quo[12:0];
          state_d  = ST_CALC;
        end
      end
      ST_CALC: begin
        thr_d    = thr_sl[14:0];
        last_d   = thr_sl[14:0];
        lim_d[0] = !armed_q || (sreq_q <= -16'sd4500);
        lim_d[1] = !armed_q || (sreq_q >= 16'sd4500);
        lim_d[2] = !armed_q || (thr_sl <= -ceil_s);
        lim_d[3] = !armed_q || (thr_sl >= ceil_s);
        if (!armed_q) begin
          drv_d[0] = 15'sd0;
          drv_d[1] = 15'sd0;
          rel_d    = 2'b00;
          state_d  = ST_DONE;
        end else begin
          state_d = ST_MIXL;
        end
      end
      ST_MIXL, ST_MIXR: begin
        // rounded 10000 * sum / den, half away from zero
        div_num = DIV_NW'(mix_mag[18:0]) * DIV_NW'(20000) + DIV_NW'(mix_den);
        div_den = DIV_DW'({mix_den, 1'b0});
        if (!issued_q) begin
          div_start = 1'b1;
          issued_d  = 1'b1;
        end else if (div_st.done) begin
          issued_d = 1'b0;
          if (state_q == ST_MIXL) begin
            drv_d[0] = (mix_sum < 20'sd0) ? -$signed(div_quo[14:0]) : $signed(div_quo[14:0]);
            state_d  = ST_MIXR;
          end else begin
            drv_d[1] = (mix_sum < 20'sd0) ? -$signed(div_quo[14:0]) : $signed(div_quo[14:0]);
            k_d      = 1'b0;
            state_d  = ST_FLR;
          end
        end
      end
      ST_FLR: begin
        // x' = sign * (100*floor + round(|x| * (100 - floor) / 100))
        div_num = DIV_NW'(axk_s[13:0]) * DIV_NW'(7'd100 - 7'(fl)) * DIV_NW'(2) +
                  DIV_NW'(100);
        div_den = DIV_DW'(200);
        if (xk == 15'sd0) begin
          xs_d    = 15'sd0;
          state_d = ST_REL;
        end else if (!issued_q) begin
          div_start = 1'b1;
          issued_d  = 1'b1;
        end else if (div_st.done) begin
          issued_d = 1'b0;
          neg_d    = xk < 15'sd0;
          xs_d     = (xk < 15'sd0) ? -$signed(fl_mag) : $signed(fl_mag);
          state_d  = expo_on ? ST_EXP1 : ST_REL;
        end
      end
      ST_EXP1: begin
        mag_d   = mag_v;
        u_d     = u_s[10:0];
        sq_d    = 22'(u_s[10:0]) * 22'(u_s[10:0]);
        em_d    = 26'(expo_q) * $signed(26'({1'b0, mag_v}));
        state_d = ST_EXP2;
      end
      ST_EXP2: begin
        n_d     = n_s[28:0];
        state_d = ST_SQRT;
      end
      ST_SQRT: begin
        if (!issued_q) begin
          sq_start = 1'b1;
          issued_d = 1'b1;
        end else if (sq_st.done) begin
          issued_d = 1'b0;
          state_d  = ST_EXPD;
        end
      end
      ST_EXPD: begin
        // |y| = round(20000 * mag * 2^12 / (root + c * 2^12))
        div_num = ((DIV_NW'(mag_q) * DIV_NW'(20000)) << 13) + DIV_NW'(den_e);
        div_den = DIV_DW'({den_e, 1'b0});
        if (!issued_q) begin
          div_start = 1'b1;
          issued_d  = 1'b1;
        end else if (div_st.done) begin
          issued_d = 1'b0;
          xs_d     = neg_q ? -$signed({1'b0, y_v}) : $signed({1'b0, y_v});
          state_d  = ST_REL;
        end
      end
      ST_REL: begin
        drv_d[k_q] = rel_x;
        rel_d[k_q] = rel_k;
        if (k_q) begin
          state_d = ST_DONE;
        end else begin
          k_d     = 1'b1;
          state_d = ST_FLR;
        end
      end
      ST_DONE: begin
        // hold until the output register is free
        if (!ov_q || out_ready_i) begin
          ov_d    = 1'b1;
          ol_d    = drv_q[0];
          or_d    = drv_q[1];
          orl_d   = rel_q[0];
          orr_d   = rel_q[1];
          om_d    = armed_q ? MODE_DRIVE : (dzpwm_q ? MODE_ZERO : MODE_TRIM);
          olim_d  = lim_q;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      issued_q <= 1'b0;
      k_q      <= 1'b0;
      last_q   <= 15'sd0;
      ov_q     <= 1'b0;
    end else begin
      state_q  <= state_d;
      issued_q <= issued_d;
      k_q      <= k_d;
      last_q   <= last_d;
      ov_q     <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    armed_q  <= armed_d;
    treq_q   <= treq_d;
    sreq_q   <= sreq_d;
    dt_q     <= dt_d;
    step_q   <= step_d;
    thr_q    <= thr_d;
    lim_q    <= lim_d;
    drv_q[0] <= drv_d[0];
    drv_q[1] <= drv_d[1];
    rel_q    <= rel_d;
    xs_q     <= xs_d;
    neg_q    <= neg_d;
    mag_q    <= mag_d;
    u_q      <= u_d;
    sq_q     <= sq_d;
    em_q     <= em_d;
    n_q      <= n_d;
    ol_q     <= ol_d;
    or_q     <= or_d;
    orl_q    <= orl_d;
    orr_q    <= orr_d;
    om_q     <= om_d;
    olim_q   <= olim_d;
  end

  assign out_valid_o            = ov_q;
  assign left_drive_o           = ol_q;
  assign right_drive_o          = or_q;
  assign relay_left_o           = orl_q;
  assign relay_right_o          = orr_q;
  assign output_mode_o          = om_q;
  assign steer_left_limit_o     = olim_q[0];
  assign steer_right_limit_o    = olim_q[1];
  assign throttle_lower_limit_o = olim_q[2];
  assign throttle_upper_limit_o = olim_q[3];

  // a new transaction is taken only with both shared units at rest
  a_idle_units: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> (!div_st.busy && !sq_st.busy))
    else $error("input taken while a shared unit is busy");

  // the kept throttle never leaves full scale
  a_last_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (last_q <= 15'sd10000) && (last_q >= -15'sd10000))
    else $error("last throttle out of range");

  // a disarmed result carries no drive and no relay
  a_disarm_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (output_mode_o != MODE_DRIVE)) |->
    (left_drive_o == 15'sd0 && right_drive_o == 15'sd0 && !relay_left_o && !relay_right_o))
    else $error("disarmed result with nonzero drive");

endmodule

// ----- bench/tb_skid_steer_throttle_mixer.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_skid_steer_throttle_mixer: self-checking bench of the skid-steer mixer
// Drives control ticks through the valid/ready input, predicts each result
// with an integer model of slew, mix, floor offset, thrust curve and relays,
// and compares every result transaction field by field, in order.
// ----------------------------------------------------------------------------
module tb_skid_steer_throttle_mixer;
  import ssm_pkg::*;

  localparam int unsigned LIMIT_CYCLES = 5000000;
  localparam int unsigned DRAIN_CYCLES = 400;

  typedef struct packed {
    logic               armed;
    logic signed [14:0] thr;
    logic signed [15:0] steer;
    logic [15:0]        dt;
  } tick_t;

  typedef struct packed {
    logic signed [14:0] left;
    logic signed [14:0] right;
    logic               rel_l;
    logic               rel_r;
    logic [1:0]         mode;
    logic               sl_lim;
    logic               sr_lim;
    logic               tl_lim;
    logic               tu_lim;
  } drive_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [2:0] cfg_addr_i = '0;
  logic [10:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic armed_i = 1'b0;
  logic signed [14:0] throttle_request_i = '0;
  logic signed [15:0] steering_request_i = '0;
  logic [15:0] dt_us_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic signed [14:0] left_drive_o, right_drive_o;
  logic relay_left_o, relay_right_o;
  logic [1:0] output_mode_o;
  logic steer_left_limit_o, steer_right_limit_o;
  logic throttle_lower_limit_o, throttle_upper_limit_o;

  always #4 clk_i = ~clk_i;

  skid_steer_throttle_mixer u_dut (.*);

  // predictor copy of the registers and the throttle history
  longint ceiling_q, floor_q, slew_q, expo_q, dzpwm_q, relay_q, rev_q, last_thr_q;

  drive_t expected_drives[$];
  int unsigned errors = 0;
  int unsigned n_ticks = 0;
  int unsigned n_results = 0;
  int unsigned cyc = 0;
  bit idle_en = 1'b1;
  int unsigned hold_off = 0;

  function automatic longint iabs(longint v);
    return v < 0 ? -v : v;
  endfunction

  function automatic longint iclamp(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic longint rdiv(longint num, longint den);
    longint q;
    q = (iabs(num) * 2 + den) / (den * 2);
    return num < 0 ? -q : q;
  endfunction

  function automatic longint int_root(longint unsigned n);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= res + b) begin
        n = n - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return longint'(res);
  endfunction

  // floor offset then thrust curve on one drive value
  function automatic longint shape(longint x, longint fl, longint e);
    bit neg;
    longint mag;
    longint unsigned n, root, den, y;
    if (x == 0) return 0;
    neg = x < 0;
    if (fl > 0) x = (neg ? -100 * fl : 100 * fl) + rdiv(x * (100 - fl), 100);
    if (e == 0 || e > 1000 || e < -1000) return x;
    mag = iabs(x);
    if (mag > 10000) mag = 10000;
    n = 100 * (1000 - e) * (1000 - e) + 40 * e * mag;
    root = int_root(n << 24);
    den = root + (longint'(10 * (1000 - e)) << 12);
    if (den == 0) den = 1;
    y = ((longint'(20000 * mag) << 12) * 2 + den) / (den * 2);
    if (y > 10000) y = 10000;
    return neg ? -longint'(y) : longint'(y);
  endfunction

  function automatic drive_t mix_tick(tick_t t);
    drive_t r;
    longint ceil, fl, thr, stepmax, a, b, d, den, x, s;
    longint drv[2];
    bit rv;
    r = '0;
    s = t.steer;
    ceil = iclamp(ceiling_q, 30, 100) * 100;
    fl = iclamp(floor_q, 0, 20);
    thr = t.armed ? iclamp(t.thr, -ceil, ceil) : 0;
    if (slew_q > 0) begin
      stepmax = slew_q * longint'(t.dt) / 10000;
      if (stepmax < 100) stepmax = 100;
      thr = iclamp(thr, last_thr_q - stepmax, last_thr_q + stepmax);
    end
    last_thr_q = thr;
    r.sl_lim = !t.armed || s <= -4500;
    r.sr_lim = !t.armed || s >= 4500;
    r.tl_lim = !t.armed || thr <= -ceil;
    r.tu_lim = !t.armed || thr >= ceil;
    if (!t.armed) begin
      r.mode = dzpwm_q ? MODE_ZERO : MODE_TRIM;
    end else begin
      r.mode = MODE_DRIVE;
      a = 20 * iclamp(s, -4500, 4500);
      b = 9 * thr;
      d = iabs(a) + iabs(b);
      den = d > 90000 ? d : 90000;
      drv[0] = rdiv(10000 * (b + a), den);
      drv[1] = rdiv(10000 * (b - a), den);
      for (int k = 0; k < 2; k++) begin
        x = shape(drv[k], fl, expo_q);
        if (relay_q) begin
          rv = rev_q[k];
          if (k == 0) r.rel_l = ((x < 0) != rv) && x != 0;
          else r.rel_r = ((x < 0) != rv) && x != 0;
          x = rv ? -iabs(x) : iabs(x);
        end
        drv[k] = x;
      end
      r.left = drv[0][14:0];
      r.right = drv[1][14:0];
    end
    return r;
  endfunction

  // write one register and mirror it into the predictor
  task automatic write_reg(logic [2:0] idx, logic [10:0] val);
    @(negedge clk_i);
    cfg_addr_i <= idx;
    cfg_data_i <= val;
    cfg_valid_i <= 1'b1;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (idx)
      CFG_CEILING: ceiling_q = val[6:0];
      CFG_FLOOR:   floor_q = val[4:0];
      CFG_SLEW:    slew_q = val[9:0];
      CFG_EXPO:    expo_q = longint'($signed(val));
      CFG_DZPWM:   dzpwm_q = val[0];
      CFG_RELAY:   relay_q = val[0];
      CFG_REVERSE: rev_q = val[1:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // valid stays high into the next transaction; an idle gap or drain drops it
  task automatic send_tick(tick_t t);
    if (idle_en && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk_i);
    end
    armed_i <= t.armed;
    throttle_request_i <= t.thr;
    steering_request_i <= t.steer;
    dt_us_i <= t.dt;
    in_valid_i <= 1'b1;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    expected_drives.push_back(mix_tick(t));
    n_ticks++;
    @(negedge clk_i);
  endtask

  // wait for every pending result, then let the sequencer settle
  task automatic drain();
    in_valid_i <= 1'b0;
    while (expected_drives.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_all(longint c, longint f, longint sl, longint e,
                           longint z, longint rl, longint rv);
    drain();
    write_reg(CFG_CEILING, 11'(c));
    write_reg(CFG_FLOOR, 11'(f));
    write_reg(CFG_SLEW, 11'(sl));
    write_reg(CFG_EXPO, 11'(e));
    write_reg(CFG_DZPWM, 11'(z));
    write_reg(CFG_RELAY, 11'(rl));
    write_reg(CFG_REVERSE, 11'(rv));
  endtask

  function automatic tick_t rand_tick();
    tick_t t;
    t.armed = $urandom_range(0, 9) != 0;
    case ($urandom_range(0, 4))
      0: t.thr = 15'($urandom);
      1: t.thr = $urandom_range(0, 1) ? 15'sd10000 : -15'sd10000;
      default: t.thr = 15'($signed($urandom_range(0, 20000)) - 10000);
    endcase
    case ($urandom_range(0, 3))
      0: t.steer = 16'($urandom);
      1: t.steer = $urandom_range(0, 1) ? 16'sd4500 : -16'sd4500;
      default: t.steer = 16'($signed($urandom_range(0, 9000)) - 4500);
    endcase
    t.dt = $urandom_range(0, 2) == 0 ? 16'($urandom) : 16'($urandom_range(0, 20000));
    return t;
  endfunction

  function automatic tick_t mk(logic a, int th, int st, int dt);
    tick_t t;
    t.armed = a;
    t.thr = 15'(th);
    t.steer = 16'(st);
    t.dt = 16'(dt);
    return t;
  endfunction

  task automatic test_directed_extremes();
    write_all(100, 0, 0, 0, 0, 0, 0);
    send_tick(mk(1, 10000, 0, 1000));
    send_tick(mk(1, -10000, 0, 0));
    send_tick(mk(1, 16383, 32767, 65535));
    send_tick(mk(1, -16384, -32768, 0));
    send_tick(mk(1, 0, 0, 100));
    send_tick(mk(1, 5000, 4500, 100));
    send_tick(mk(1, 5000, -4500, 100));
    send_tick(mk(0, 7000, 100, 100));
    write_all(30, 20, 1000, 1000, 1, 1, 3);
    send_tick(mk(1, 10000, 2000, 65535));
    send_tick(mk(1, -10000, -2000, 0));
    send_tick(mk(1, 0, 0, 0));
    send_tick(mk(0, 0, 0, 0));
    send_tick(mk(1, 3000, 4500, 65535));
    // out-of-range ceiling and floor, wide expo, unlisted index
    write_all(127, 31, 100, -1000, 0, 1, 1);
    write_reg(3'd7, 11'h7FF);
    send_tick(mk(1, 10000, 1000, 65535));
    send_tick(mk(1, -10000, -1000, 65535));
    send_tick(mk(1, 2000, -3000, 0));
    write_all(0, 0, 1, 11'h400, 0, 1, 2);
    send_tick(mk(1, 1000, 3000, 65535));
    send_tick(mk(1, -1000, -3000, 1));
    send_tick(mk(0, -1000, 0, 1));
  endtask

  task automatic test_random_phases();
    for (int ph = 0; ph < 14; ph++) begin
      write_all($urandom_range(0, 127), $urandom_range(0, 31),
                $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 1023),
                $urandom_range(0, 1) ? 0 : $signed($urandom_range(0, 2047)) - 1024,
                $urandom_range(0, 1), $urandom_range(0, 1), $urandom_range(0, 3));
      for (int i = 0; i < 110; i++) send_tick(rand_tick());
    end
  endtask

  task automatic test_backpressure();
    write_all(100, 5, 500, 300, 0, 0, 0);
    hold_off = 1500;
    for (int i = 0; i < 40; i++) send_tick(rand_tick());
    // sender pauses until everything is back
    drain();
    for (int i = 0; i < 40; i++) send_tick(rand_tick());
  endtask

  task automatic test_full_rate();
    idle_en = 1'b0;
    write_all(80, 10, 200, -500, 1, 1, 1);
    for (int i = 0; i < 150; i++) send_tick(rand_tick());
  endtask

  // receiver: random stalls, one long hold-off when asked
  always @(negedge clk_i) begin
    if (hold_off != 0) begin
      out_ready_i <= 1'b0;
      hold_off <= hold_off - 1;
    end else if (idle_en && $urandom_range(0, 4) == 0) begin
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  // compare each result transaction with the oldest prediction
  always @(posedge clk_i) begin
    drive_t got, want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got = '{left_drive_o, right_drive_o, relay_left_o, relay_right_o, output_mode_o,
              steer_left_limit_o, steer_right_limit_o, throttle_lower_limit_o,
              throttle_upper_limit_o};
      n_results++;
      if (expected_drives.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, actual %p", $time, got);
      end else begin
        want = expected_drives.pop_front();
        if (got.left !== want.left)
          $display("%0t: left_drive exp %0d act %0d", $time, want.left, got.left);
        if (got.right !== want.right)
          $display("%0t: right_drive exp %0d act %0d", $time, want.right, got.right);
        if (got.rel_l !== want.rel_l)
          $display("%0t: relay_left exp %0d act %0d", $time, want.rel_l, got.rel_l);
        if (got.rel_r !== want.rel_r)
          $display("%0t: relay_right exp %0d act %0d", $time, want.rel_r, got.rel_r);
        if (got.mode !== want.mode)
          $display("%0t: output_mode exp %0d act %0d", $time, want.mode, got.mode);
        if (got[3:0] !== want[3:0])
          $display("%0t: limit flags exp %b act %b", $time, want[3:0], got[3:0]);
        if (got !== want) errors++;
      end
    end
  end

  // watchdog on cycle count
  always @(posedge clk_i) begin
    cyc <= cyc + 1;
    if (cyc > LIMIT_CYCLES) begin
      $display("tb_skid_steer_throttle_mixer NOT OK");
      $finish;
    end
  end

  initial begin
    ceiling_q = 100; floor_q = 0; slew_q = 100; expo_q = 0;
    dzpwm_q = 0; relay_q = 0; rev_q = 0; last_thr_q = 0;
    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_directed_extremes();
    test_random_phases();
    test_backpressure();
    test_full_rate();
    drain();
    if (expected_drives.size() != 0) errors++;
    $display("Covered %0d ticks and %0d results over directed, random, stalled",
             n_ticks, n_results);
    $display("and full-rate phases with register settings from minimum to maximum.");
    if (errors == 0) begin
      $display("tb_skid_steer_throttle_mixer OK");
    end else begin
      $display("tb_skid_steer_throttle_mixer NOT OK");
    end
    $finish;
  end
endmodule

// ----- filelist.f -----
rtl/ssm_pkg.sv
rtl/ssm_div.sv
rtl/ssm_sqrt.sv
rtl/skid_steer_throttle_mixer.sv
bench/tb_skid_steer_throttle_mixer.sv
